@@ rtl/cpualu_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// cpualu_pkg
// Shared types and constants for the integer ALU with condition codes.
// ----------------------------------------------------------------------------
package cpualu_pkg;

   // Operation codes carried in the kind field
   typedef enum logic [2:0] {
      OP_ADD  = 3'd0,
      OP_ADDX = 3'd1,
      OP_SUB  = 3'd2,
      OP_CMP  = 3'd3,
      OP_AND  = 3'd4,
      OP_OR   = 3'd5
   } alu_op_type;

   // Operand size codes; the spare code behaves as long
   typedef enum logic [1:0] {
      SZ_BYTE = 2'd0,
      SZ_WORD = 2'd1,
      SZ_LONG = 2'd2
   } op_size_type;

   localparam int unsigned DATA_W = 32;

   localparam logic [DATA_W-1:0] MASK_BYTE = 32'h0000_00ff;
   localparam logic [DATA_W-1:0] MASK_WORD = 32'h0000_ffff;
   localparam logic [DATA_W-1:0] MASK_LONG = 32'hffff_ffff;
   localparam logic [DATA_W-1:0] SIGN_BYTE = 32'h0000_0080;
   localparam logic [DATA_W-1:0] SIGN_WORD = 32'h0000_8000;
   localparam logic [DATA_W-1:0] SIGN_LONG = 32'h8000_0000;

   // Condition codes, same bit order as flags_out (x is bit 4, c is bit 0)
   typedef struct packed {
      logic x;
      logic n;
      logic z;
      logic v;
      logic c;
   } flags_type;

   // One operation as held in the input register
   typedef struct packed {
      logic [2:0]        kind;
      logic [1:0]        op_size;
      logic [DATA_W-1:0] src_operand;
      logic [DATA_W-1:0] dst_operand;
   } alu_req_type;

   // What the execute logic hands back for one operation
   typedef struct packed {
      logic [DATA_W-1:0] result_value;
      logic              write_back;
      flags_type         flags;
   } alu_rsp_type;

endpackage : cpualu_pkg
`default_nettype wire

@@ rtl/cpu_alu_with_condition_codes.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// cpu_alu_with_condition_codes
// Integer ALU (add, addx, sub, cmp, and, or) with X N Z V C condition codes.
// ----------------------------------------------------------------------------
// One operation per item at byte, word or long size; sub and cmp form
// dst - src, and only the low size bits of the result come from the ALU,
// the rest are copied from dst. The block accepts one item every cycle
// while the output is not stalled; each result passes through the input
// register and then the result register. The rate is set by the flag
// loop: each item reads the condition codes left by the one before it,
// and that loop closes through the flag register as the item moves from
// the input register to the result register. Flags reset to all clear.
// Spare kind codes act as a no-op
// (dst is passed through, no write-back, flags unchanged); the spare size
// code acts as long. Back-pressure on rsp_tready propagates to req_tready
// only when both registers are full.
// ----------------------------------------------------------------------------
module cpu_alu_with_condition_codes (
   input  wire         clock,
   input  wire         reset,

   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [63:0] req_tdata,   // [31:0] src_operand, [63:32] dst_operand
   input  wire  [4:0]  req_tuser,   // [2:0] kind, [4:3] op_size

   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [39:0] rsp_tdata,   // [31:0] result_value, [36:32] flags_out,
                                    // [39:37] zero
   output logic        rsp_tuser    // [0] write_back
);

   // input register
   logic                    s1_valid_ff, s1_valid_in;
   cpualu_pkg::alu_req_type s1_req_ff,   s1_req_in;

   // result register
   logic                    s2_valid_ff, s2_valid_in;
   cpualu_pkg::alu_rsp_type s2_rsp_ff,   s2_rsp_in;

   // architectural condition codes
   cpualu_pkg::flags_type   flags_ff,    flags_in;

   cpualu_pkg::alu_rsp_type exec_rsp;

   logic s2_free;
   logic s1_move;
   logic req_fire;

   // handshake: result register frees when empty or being taken
   assign s2_free    = !s2_valid_ff || rsp_tready;
   assign s1_move    = s1_valid_ff && s2_free;
   assign req_tready = !s1_valid_ff || s1_move;
   assign req_fire   = req_tvalid && req_tready;

   cpualu_exec u_exec (
      .req       (s1_req_ff),
      .flags_cur (flags_ff),
      .rsp       (exec_rsp)
   );

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_req_in   = s1_req_ff;
      if (req_fire) begin
         s1_valid_in           = 1'b1;
         s1_req_in.kind        = req_tuser[2:0];
         s1_req_in.op_size     = req_tuser[4:3];
         s1_req_in.src_operand = req_tdata[31:0];
         s1_req_in.dst_operand = req_tdata[63:32];
      end else if (s1_move) begin
         s1_valid_in = 1'b0;
      end

      s2_valid_in = s2_valid_ff;
      s2_rsp_in   = s2_rsp_ff;
      flags_in    = flags_ff;
      if (s1_move) begin
         s2_valid_in = 1'b1;
         s2_rsp_in   = exec_rsp;
         flags_in    = exec_rsp.flags;   // commit flags as the item leaves stage 1
      end else if (rsp_tready) begin
         s2_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         flags_ff    <= '0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         flags_ff    <= flags_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_req_ff <= s1_req_in;
      s2_rsp_ff <= s2_rsp_in;
   end

   assign rsp_tvalid = s2_valid_ff;
   assign rsp_tdata  = {3'b000, s2_rsp_ff.flags, s2_rsp_ff.result_value};
   assign rsp_tuser  = s2_rsp_ff.write_back;

   // ---------------------------------------------------------------------
   // assertions
   // ---------------------------------------------------------------------

   // flags only move when an item commits from the input register
   a_flags_hold: assert property (@(posedge clock) disable iff (reset)
      !s1_move |=> $stable(flags_ff))
      else $error("condition codes changed without an item committing");

   // the item on the output always carries the current condition codes
   a_flags_match: assert property (@(posedge clock) disable iff (reset)
      s2_valid_ff |-> (s2_rsp_ff.flags == flags_ff))
      else $error("reported flags differ from flag register");

   // a stalled result register must block the input register
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (s2_valid_ff && !rsp_tready) |-> !s1_move)
      else $error("input register advanced into a stalled result register");

   // empty input register always takes a new item
   a_ready_empty: assert property (@(posedge clock) disable iff (reset)
      !s1_valid_ff |-> req_tready)
      else $error("ready low with empty input register");

endmodule : cpu_alu_with_condition_codes
`default_nettype wire

@@ rtl/cpualu_exec.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// cpualu_exec
// Combinational execute logic: sized add/addx/sub/cmp/and/or and flag update.
// ----------------------------------------------------------------------------
module cpualu_exec (
   input  cpualu_pkg::alu_req_type req,
   input  cpualu_pkg::flags_type   flags_cur,
   output cpualu_pkg::alu_rsp_type rsp
);

   logic [cpualu_pkg::DATA_W-1:0] mask;
   logic [cpualu_pkg::DATA_W-1:0] sign;
   logic [cpualu_pkg::DATA_W-1:0] s_val;
   logic [cpualu_pkg::DATA_W-1:0] d_val;
   logic [cpualu_pkg::DATA_W-1:0] res;
   logic [cpualu_pkg::DATA_W:0]   wide;
   logic                          carry;
   logic                          sa;
   logic                          sd;
   logic                          sr;
   logic                          zero;
   cpualu_pkg::flags_type         f;

   always_comb begin
      unique case (cpualu_pkg::op_size_type'(req.op_size))
         cpualu_pkg::SZ_BYTE: begin
            mask = cpualu_pkg::MASK_BYTE;
            sign = cpualu_pkg::SIGN_BYTE;
         end
         cpualu_pkg::SZ_WORD: begin
            mask = cpualu_pkg::MASK_WORD;
            sign = cpualu_pkg::SIGN_WORD;
         end
         default: begin
            mask = cpualu_pkg::MASK_LONG;
            sign = cpualu_pkg::SIGN_LONG;
         end
      endcase

      s_val = req.src_operand & mask;
      d_val = req.dst_operand & mask;

      unique case (cpualu_pkg::alu_op_type'(req.kind))
         cpualu_pkg::OP_ADD:  wide = {1'b0, d_val} + {1'b0, s_val};
         cpualu_pkg::OP_ADDX: wide = {1'b0, d_val} + {1'b0, s_val}
                                     + {{cpualu_pkg::DATA_W{1'b0}}, flags_cur.x};
         cpualu_pkg::OP_SUB,
         cpualu_pkg::OP_CMP:  wide = {1'b0, d_val} - {1'b0, s_val};
         cpualu_pkg::OP_AND:  wide = {1'b0, d_val & s_val};
         default:             wide = {1'b0, d_val | s_val};
      endcase

      // anything above the size msb is the carry or borrow
      carry = |(wide & ~{1'b0, mask});
      res   = wide[cpualu_pkg::DATA_W-1:0] & mask;
      sa    = |(s_val & sign);
      sd    = |(d_val & sign);
      sr    = |(res & sign);
      zero  = (res == '0);

      f           = flags_cur;
      rsp.write_back = 1'b1;
      unique case (cpualu_pkg::alu_op_type'(req.kind))
         cpualu_pkg::OP_ADD: begin
            f.x = carry;
            f.n = sr;
            f.z = zero;
            f.v = (sa == sd) && (sr != sd);
            f.c = carry;
         end
         cpualu_pkg::OP_ADDX: begin
            f.x = carry;
            f.n = sr;
            f.z = flags_cur.z && zero;   // sticky across a multi-precision chain
            f.v = (sa == sd) && (sr != sd);
            f.c = carry;
         end
         cpualu_pkg::OP_SUB: begin
            f.x = carry;
            f.n = sr;
            f.z = zero;
            f.v = (sd != sa) && (sr != sd);
            f.c = carry;
         end
         cpualu_pkg::OP_CMP: begin
            f.n = sr;
            f.z = zero;
            f.v = (sd != sa) && (sr != sd);
            f.c = carry;
            rsp.write_back = 1'b0;
         end
         cpualu_pkg::OP_AND,
         cpualu_pkg::OP_OR: begin
            f.n = sr;
            f.z = zero;
            f.v = 1'b0;
            f.c = 1'b0;
         end
         default: begin
            rsp.write_back = 1'b0;       // spare kind: no-op
         end
      endcase

      if (req.kind > 3'(cpualu_pkg::OP_OR)) begin
         rsp.result_value = req.dst_operand;
      end else begin
         rsp.result_value = (req.dst_operand & ~mask) | res;
      end
      rsp.flags = f;
   end

endmodule : cpualu_exec
`default_nettype wire

@@ tb/cpu_alu_with_condition_codes_tb.sv @@
// ----------------------------------------------------------------------------
// cpu_alu_with_condition_codes_tb
// Self-checking bench for the integer ALU with X N Z V C condition codes.
// ----------------------------------------------------------------------------
// A directed burst hits the size boundaries, carry/borrow/overflow corners,
// the extend chain and the spare kind and size codes. Random operations
// follow, many of them add or sub heads with addx chains so the X flag feeds through.
// A scoreboard keeps its own copy of the condition codes, predicts every
// result in accept order and checks the result stream item by item.
// ----------------------------------------------------------------------------
module cpu_alu_with_condition_codes_tb;

   // Spare codes the block must tolerate
   localparam logic [2:0] KIND_SPARE6 = 3'd6;
   localparam logic [2:0] KIND_SPARE7 = 3'd7;
   localparam logic [1:0] SZ_SPARE    = 2'd3;

   localparam int RANDOM_OPS   = 850;
   localparam int QUIET_TAIL   = 100;   // last items run with no idling at all
   localparam int STALL_LIMIT  = 500;   // cycles with no item moving either way
   localparam int REPORT_LIMIT = 10;

   // -------------------------------------------------------------------------
   // Scoreboard: predicts result, write-back and flags per accepted operation
   // -------------------------------------------------------------------------
   class alu_ccr_scoreboard;
      cpualu_pkg::flags_type    ccr;                 // predicted condition codes
      cpualu_pkg::alu_rsp_type  pending_results[$];  // oldest first
      int                       mismatches;
      int                       checked;

      function new();
         ccr        = '0;
         mismatches = 0;
         checked    = 0;
      endfunction

      function int pending();
         return pending_results.size();
      endfunction

      // Work out the result of one accepted operation and queue it
      function void note_op(logic [2:0] kind, logic [1:0] size,
                            logic [31:0] src, logic [31:0] dst);
         logic [31:0] mask, sign, s, d, res;
         logic [32:0] wide;
         logic        carry, sa, sd, sr;
         cpualu_pkg::flags_type   f;
         cpualu_pkg::alu_rsp_type r;
         f = ccr;
         case (size)
            cpualu_pkg::SZ_BYTE: begin
               mask = cpualu_pkg::MASK_BYTE;
               sign = cpualu_pkg::SIGN_BYTE;
            end
            cpualu_pkg::SZ_WORD: begin
               mask = cpualu_pkg::MASK_WORD;
               sign = cpualu_pkg::SIGN_WORD;
            end
            default: begin
               mask = cpualu_pkg::MASK_LONG;
               sign = cpualu_pkg::SIGN_LONG;
            end
         endcase
         s = src & mask;
         d = dst & mask;
         r.write_back = 1'b1;
         if (kind > cpualu_pkg::OP_OR) begin
            // spare kind: pass dst through, flags untouched
            r.result_value = dst;
            r.write_back   = 1'b0;
            r.flags        = f;
            pending_results.push_back(r);
            return;
         end
         case (kind)
            cpualu_pkg::OP_ADD:  wide = {1'b0, d} + {1'b0, s};
            cpualu_pkg::OP_ADDX: wide = {1'b0, d} + {1'b0, s} + {32'b0, f.x};
            cpualu_pkg::OP_SUB,
            cpualu_pkg::OP_CMP:  wide = {1'b0, d} - {1'b0, s};
            cpualu_pkg::OP_AND:  wide = {1'b0, d & s};
            default:             wide = {1'b0, d | s};
         endcase
         res   = wide[31:0] & mask;
         carry = |(wide & ~{1'b0, mask});
         sa    = |(s & sign);
         sd    = |(d & sign);
         sr    = |(res & sign);
         f.n   = sr;
         case (kind)
            cpualu_pkg::OP_ADD, cpualu_pkg::OP_ADDX: begin
               f.c = carry;
               f.x = carry;
               f.v = (sa == sd) && (sr != sd);
               if (kind == cpualu_pkg::OP_ADD)
                  f.z = (res == 0);
               else if (res != 0)
                  f.z = 1'b0;             // addx only ever clears Z
            end
            cpualu_pkg::OP_SUB, cpualu_pkg::OP_CMP: begin
               f.c = carry;
               if (kind == cpualu_pkg::OP_SUB)
                  f.x = carry;
               else
                  r.write_back = 1'b0;    // compare keeps X, writes nothing
               f.z = (res == 0);
               f.v = (sd != sa) && (sr != sd);
            end
            default: begin
               f.z = (res == 0);
               f.v = 1'b0;
               f.c = 1'b0;
            end
         endcase
         ccr            = f;
         r.result_value = (dst & ~mask) | res;
         r.flags        = f;
         pending_results.push_back(r);
      endfunction

      // Compare one delivered result against the oldest prediction
      function void check_result(logic [31:0] value, logic wb, logic [4:0] flag_bits);
         cpualu_pkg::alu_rsp_type r;
         checked++;
         if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("MISMATCH: unexpected result value=%h wb=%b flags=%b",
                        value, wb, flag_bits);
            return;
         end
         r = pending_results.pop_front();
         if (value !== r.result_value || wb !== r.write_back || flag_bits !== r.flags) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display({"MISMATCH: value exp %h got %h | wb exp %b got %b",
                         " | XNZVC exp %b got %b"},
                        r.result_value, value, r.write_back, wb, r.flags, flag_bits);
         end
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // DUT hookup
   // -------------------------------------------------------------------------
   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [63:0] req_tdata;   // [31:0] src_operand, [63:32] dst_operand
   logic [4:0]  req_tuser;   // [2:0] kind, [4:3] op_size
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [39:0] rsp_tdata;   // [31:0] result_value, [36:32] flags_out, [39:37] zero
   logic        rsp_tuser;   // [0] write_back

   cpu_alu_with_condition_codes dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   alu_ccr_scoreboard sb = new();

   int  send_idle_pct  = 15;   // chance of an idle burst before an item
   int  recv_stall_pct = 15;   // chance the receiver stalls instead of taking
   bit  quiet          = 1'b0; // set for the tail: no idling on either side
   int  ops_accepted   = 0;
   int  kind_hits [8];
   int  spare_size_hits = 0;

   // -------------------------------------------------------------------------
   // Clock and reset
   // -------------------------------------------------------------------------
   initial clock = 1'b0;
   always #4 clock = ~clock;

   // -------------------------------------------------------------------------
   // Monitor: both handshakes sampled at the rising edge. Results are checked
   // before the same-edge input is predicted; latency makes them unrelated.
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready)
            sb.check_result(rsp_tdata[31:0], rsp_tuser, rsp_tdata[36:32]);
         if (req_tvalid && req_tready) begin
            sb.note_op(req_tuser[2:0], req_tuser[4:3], req_tdata[31:0], req_tdata[63:32]);
            ops_accepted++;
            kind_hits[req_tuser[2:0]]++;
            if (req_tuser[4:3] == SZ_SPARE)
               spare_size_hits++;
         end
      end
   end

   // -------------------------------------------------------------------------
   // Watchdog: ends the run when nothing moves for too long
   // -------------------------------------------------------------------------
   initial begin
      int idle_run;
      idle_run = 0;
      while (idle_run < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            idle_run = 0;
         else
            idle_run++;
      end
      $display("Watchdog: no item moved for %0d cycles, %0d results outstanding",
               STALL_LIMIT, sb.pending());
      $display("[FAIL] regression broken");
      $finish;
   end

   // -------------------------------------------------------------------------
   // Receiver: alternates stall bursts with runs of ready cycles
   // -------------------------------------------------------------------------
   initial begin
      rsp_tready <= 1'b0;
      while (reset) @(posedge clock);
      forever begin
         if (quiet) begin
            rsp_tready <= 1'b1;
            @(posedge clock);
         end else if ($urandom_range(0, 99) < recv_stall_pct) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
            repeat ($urandom_range(1, 16)) @(posedge clock);
         end
      end
   end

   // -------------------------------------------------------------------------
   // Sender tasks
   // -------------------------------------------------------------------------
   // Present one operation and hold it until accepted. tvalid stays high from
   // one item to the next unless an idle burst goes in between.
   task automatic send_op(input logic [2:0] kind, input logic [1:0] size,
                          input logic [31:0] src, input logic [31:0] dst);
      if (!quiet && $urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {dst, src};
      req_tuser  <= {size, kind};
      do @(posedge clock); while (!req_tready);
   endtask

   // Hold off the sender until every predicted result has come back. The
   // item accepted at the last edge may not be queued yet, so the task waits on
   // the clock before looking at the queue.
   task automatic drain_results();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.pending() > 0) @(posedge clock);
   endtask

   // Operand picker biased toward sign and carry boundaries
   function automatic logic [31:0] pick_operand();
      case ($urandom_range(0, 9))
         0:       return 32'h0;
         1:       return cpualu_pkg::MASK_LONG;
         2:       return cpualu_pkg::SIGN_BYTE | ($urandom() & ~cpualu_pkg::MASK_BYTE);
         3:       return cpualu_pkg::SIGN_WORD | ($urandom() & ~cpualu_pkg::MASK_WORD);
         4:       return cpualu_pkg::SIGN_LONG;
         5:       return (cpualu_pkg::SIGN_BYTE - 1) | ($urandom() & ~cpualu_pkg::MASK_BYTE);
         6:       return (cpualu_pkg::SIGN_WORD - 1) | ($urandom() & ~cpualu_pkg::MASK_WORD);
         7:       return cpualu_pkg::SIGN_LONG - 1;
         default: return $urandom();
      endcase
   endfunction

   function automatic logic [2:0] pick_kind();
      if ($urandom_range(0, 99) < 4)
         return $urandom_range(0, 1) ? KIND_SPARE6 : KIND_SPARE7;
      return 3'($urandom_range(0, 5));
   endfunction

   // -------------------------------------------------------------------------
   // Main sequence
   // -------------------------------------------------------------------------
   initial begin
      int          sent, chain, k;
      logic [1:0]  sz;

      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed corners: size boundaries, X through addx, compare and logic
      // ops leaving X alone, spare kind and size codes.
      send_op(cpualu_pkg::OP_ADD,  cpualu_pkg::SZ_BYTE, 32'h0000_0001, 32'hAAAA_AA7F);
      send_op(cpualu_pkg::OP_ADD,  cpualu_pkg::SZ_BYTE, 32'h0000_0001, 32'h1234_56FF);
      send_op(cpualu_pkg::OP_ADDX, cpualu_pkg::SZ_BYTE, 32'h0000_0000, 32'h0000_0000);
      send_op(cpualu_pkg::OP_ADD,  cpualu_pkg::SZ_LONG, 32'h0000_0001, 32'hFFFF_FFFF);
      send_op(cpualu_pkg::OP_ADDX, cpualu_pkg::SZ_LONG, 32'hFFFF_FFFF, 32'h0000_0000);
      send_op(cpualu_pkg::OP_ADDX, cpualu_pkg::SZ_WORD, 32'h0000_0000, 32'hFFFF_0000);
      send_op(cpualu_pkg::OP_ADD,  cpualu_pkg::SZ_WORD, 32'hFFFF_FFFF, 32'h0000_FFFF);
      send_op(cpualu_pkg::OP_ADDX, cpualu_pkg::SZ_BYTE, 32'h0000_0080, 32'h0000_0080);
      send_op(cpualu_pkg::OP_SUB,  cpualu_pkg::SZ_WORD, 32'h0000_0001, 32'h5555_8000);
      send_op(cpualu_pkg::OP_SUB,  cpualu_pkg::SZ_BYTE, 32'h0000_0001, 32'h0000_0000);
      send_op(cpualu_pkg::OP_CMP,  cpualu_pkg::SZ_LONG, 32'h0000_0007, 32'h0000_0005);
      send_op(cpualu_pkg::OP_CMP,  cpualu_pkg::SZ_BYTE, 32'hFFFF_FF42, 32'h0000_0042);
      send_op(cpualu_pkg::OP_CMP,  cpualu_pkg::SZ_WORD, 32'h0000_0001, 32'h0000_8000);
      send_op(cpualu_pkg::OP_AND,  cpualu_pkg::SZ_LONG, 32'h0000_0000, 32'hFFFF_FFFF);
      send_op(cpualu_pkg::OP_OR,   cpualu_pkg::SZ_WORD, 32'h0000_0000, 32'h0000_8000);
      send_op(cpualu_pkg::OP_AND,  cpualu_pkg::SZ_BYTE, 32'h0000_0080, 32'hFFFF_FFFF);
      send_op(cpualu_pkg::OP_OR,   cpualu_pkg::SZ_LONG, 32'h0000_0000, 32'h0000_0000);
      send_op(KIND_SPARE6, cpualu_pkg::SZ_WORD, 32'hDEAD_BEEF, 32'h0BAD_F00D);
      send_op(KIND_SPARE7, cpualu_pkg::SZ_BYTE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_op(cpualu_pkg::OP_ADD,  SZ_SPARE, 32'h0000_0001, 32'h7FFF_FFFF); // spare size is long
      send_op(cpualu_pkg::OP_SUB,  SZ_SPARE, 32'h0000_0001, 32'h8000_0000);
      send_op(cpualu_pkg::OP_SUB,  cpualu_pkg::SZ_LONG, 32'h8000_0000, 32'h0000_0000);
      send_op(cpualu_pkg::OP_SUB,  cpualu_pkg::SZ_BYTE, 32'h0000_007F, 32'h0000_0080);
      drain_results();

      // Random phase. Roughly a third are multi-precision chains: an add or
      // subtract followed by addx items so X travels between operations.
      sent = 0;
      while (sent < RANDOM_OPS) begin
         if (sent % 64 == 0) begin
            k = $urandom_range(0, 2);
            send_idle_pct  = (k == 0) ? 0 : (k == 1) ? 10 : 35;
            k = $urandom_range(0, 2);
            recv_stall_pct = (k == 0) ? 0 : (k == 1) ? 15 : 45;
         end
         if (sent >= RANDOM_OPS - QUIET_TAIL)
            quiet = 1'b1;
         if (sent == RANDOM_OPS / 2)
            drain_results();

         if ($urandom_range(0, 2) == 0) begin
            sz    = 2'($urandom_range(0, 3));
            chain = $urandom_range(1, 4);
            send_op($urandom_range(0, 1) ? cpualu_pkg::OP_ADD : cpualu_pkg::OP_SUB, sz,
                    pick_operand(), pick_operand());
            sent++;
            for (int i = 0; i < chain && sent < RANDOM_OPS; i++) begin
               send_op(cpualu_pkg::OP_ADDX, sz, pick_operand(), pick_operand());
               sent++;
            end
         end else begin
            send_op(pick_kind(), 2'($urandom_range(0, 3)), pick_operand(), pick_operand());
            sent++;
         end
      end

      // Flush: wait for the queue to empty, then let the clock run on to catch strays
      drain_results();
      repeat (8) @(posedge clock);

      $display("Run covered %0d operations, %0d results checked, %0d mismatches",
               ops_accepted, sb.checked, sb.mismatches);
      $display("  add %0d addx %0d sub %0d cmp %0d and %0d or %0d spare kinds %0d spare size %0d",
               kind_hits[cpualu_pkg::OP_ADD], kind_hits[cpualu_pkg::OP_ADDX],
               kind_hits[cpualu_pkg::OP_SUB], kind_hits[cpualu_pkg::OP_CMP],
               kind_hits[cpualu_pkg::OP_AND], kind_hits[cpualu_pkg::OP_OR],
               kind_hits[KIND_SPARE6] + kind_hits[KIND_SPARE7], spare_size_hits);
      if (sb.mismatches == 0 && sb.pending() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

@@ files.f @@
rtl/cpualu_pkg.sv
rtl/cpualu_exec.sv
rtl/cpu_alu_with_condition_codes.sv
tb/cpu_alu_with_condition_codes_tb.sv
